@@ sv/lcs_pkg.sv @@
package lcs_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        REG_DARK_LABEL  = 1'b0,
        REG_LIGHT_LABEL = 1'b1
    } cfg_reg_t;

    localparam logic [31:0] DARK_LABEL_RESET  = 32'hFF00_0000;
    localparam logic [31:0] LIGHT_LABEL_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;

    // Luminance weights in Q0.16, summing to one.
    localparam logic [15:0] WEIGHT_RED   = 16'd13933;
    localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

    // Packed color as it travels on the buses.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    // Fifth power of a Q30 value, truncating after each product.
    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] x;
        x = r;
        for (int i = 0; i < 4; i++)
        begin
            x = (x * r) >> 30;
        end
        return x;
    endfunction

    // One entry of the sRGB linearization table, evaluated at elaboration.
    function automatic logic [63:0] lin_entry(input int v, input int frac);
        logic [63:0] vv;
        logic [63:0] num;
        logic [63:0] tq;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lin;
        vv = 64'(v);
        if (v <= 10)
        begin
            num = (((64'd25 * vv) << frac) * 64'd2) + 64'd82365;
            return num / 64'd164730;
        end
        tq = (((64'd200 * vv + 64'd2805) << 30) + 64'd26902) / 64'd53805;
        t2 = (tq * tq + (64'd1 << 29)) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        // Fifth root of t squared by bisection.
        while (lo < hi)
        begin
            mid = (lo + hi + 64'd1) >> 1;
            if (pow5_q30(mid) <= t2)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        lin = (t2 * lo) >> 30;
        return (lin + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

@@ sv/lcs_divider.sv @@
module lcs_divider
    import lcs_pkg::*;
#(
    parameter int RW = 37,
    parameter int QB = 13,
    parameter int FB = 8,
    parameter int PW = 65
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] num,
    input  logic [RW-1:0] den,
    input  logic [PW-1:0] in_payload,
    output logic          out_valid,
    output logic [QB-1:0] quotient,
    output logic [PW-1:0] out_payload
);

    // Integer bits of the quotient.
    localparam int IB = QB - FB;

    // Stage k holds the partial remainder after k quotient bits.
    logic          valid_reg   [QB+1];
    logic [RW-1:0] rem_reg     [QB+1];
    logic [RW-1:0] den_reg     [QB+1];
    logic [QB-1:0] bits_reg    [QB+1];
    logic [QB-1:0] quot_reg    [QB+1];
    logic [PW-1:0] payload_reg [QB+1];

    // Input stage: the quotient is known to fit QB bits, so the top of the
    // shifted numerator starts as the remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]     <= num >> IB;
            den_reg[0]     <= den;
            bits_reg[0]    <= {num[IB-1:0], {FB{1'b0}}};
            quot_reg[0]    <= '0;
            payload_reg[0] <= in_payload;
        end
    end

    // One restoring step per stage.
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [RW:0] trial;
        logic        fits;

        assign trial = {rem_reg[k], bits_reg[k][QB-1]};
        assign fits  = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]     <= fits ? RW'(trial - {1'b0, den_reg[k]}) : trial[RW-1:0];
                den_reg[k+1]     <= den_reg[k];
                bits_reg[k+1]    <= {bits_reg[k][QB-2:0], 1'b0};
                quot_reg[k+1]    <= {quot_reg[k][QB-2:0], fits};
                payload_reg[k+1] <= payload_reg[k];
            end
        end
    end

    assign out_valid   = valid_reg[QB];
    assign quotient    = quot_reg[QB];
    assign out_payload = payload_reg[QB];

endmodule

@@ sv/label_contrast_selector.sv @@
// Label contrast selector. Each input transaction carries a fill and a
// background color; the fill is blended over the background with the fill's
// alpha, and the block returns whichever configured label color (dark or
// light) gives the higher WCAG 2 contrast against the blend, dark on a tie,
// together with the blend itself and the contrast ratio in fixed point.
// The block takes one transaction per cycle while s_tready is high; its
// quotient divider resolves one bit per pipeline stage. A two-entry output
// buffer lets the pipeline keep accepting while a result waits.
// Label registers must be written while no transaction is in flight.
module label_contrast_selector
    import lcs_pkg::*;
#(
    parameter int LUMA_FRAC_BITS  = 16,
    parameter int RATIO_FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // fill_color[31:0], background_color[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // label_color[31:0], effective_color[63:32],
                                   // contrast_q8[76:64], zero pad
    output logic        m_tuser    // chose_dark
);

    localparam int LINW = LUMA_FRAC_BITS + 1;
    localparam int LUMW = LUMA_FRAC_BITS + 17;
    localparam int RW   = LUMA_FRAC_BITS + 21;
    localparam int HW   = (RW + 1) / 2;
    localparam int PPW  = 2 * HW;
    localparam int XW   = 2 * RW;
    localparam int QB   = RATIO_FRAC_BITS + 5;
    localparam int PW   = 65;
    localparam int QXW  = QB + 13;

    // Linearization table, built at elaboration.
    logic [LINW-1:0] lin_rom [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_rom
        localparam logic [63:0] ENTRY = lin_entry(g, LUMA_FRAC_BITS);
        assign lin_rom[g] = ENTRY[LINW-1:0];
    end

    function automatic logic [LUMW-1:0] luma(input color_t c);
        logic [LUMW-1:0] pr;
        logic [LUMW-1:0] pg;
        logic [LUMW-1:0] pb;
        pr = LUMW'(WEIGHT_RED)   * LUMW'(lin_rom[c.red]);
        pg = LUMW'(WEIGHT_GREEN) * LUMW'(lin_rom[c.green]);
        pb = LUMW'(WEIGHT_BLUE)  * LUMW'(lin_rom[c.blue]);
        return pr + pg + pb;
    endfunction

    function automatic logic [15:0] blend_sum(input logic [7:0] f, input logic [7:0] b,
                                              input logic [7:0] a);
        return 16'(f) * 16'(a) + 16'(b) * 16'(8'd255 - a) + 16'd127;
    endfunction

    // Exact floor(x / 255) for the blend range.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    // Contrast fraction terms: 20 * lum + one.
    function automatic logic [RW-1:0] ratio_term(input logic [LUMW-1:0] l);
        return (RW'(l) << 4) + (RW'(l) << 2) + (RW'(1) << (LUMA_FRAC_BITS + 16));
    endfunction

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Label color registers and their luminances.
    logic [31:0]     dark_reg;
    logic [31:0]     light_reg;
    logic [LUMW-1:0] lum_dark_reg;
    logic [LUMW-1:0] lum_light_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg  <= DARK_LABEL_RESET;
            light_reg <= LIGHT_LABEL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DARK_LABEL)
                dark_reg <= cfg_data;
            else
                light_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        lum_dark_reg  <= luma(dark_reg);
        lum_light_reg <= luma(light_reg);
    end

    // Valid bits of stages one through ten.
    logic [10:1] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[9:1], s_tvalid};
    end

    // Stage 1: input capture.
    color_t fill_reg;
    color_t back_reg;
    // Stage 2: blend sums.
    logic [15:0] sr_reg, sg_reg, sb_reg;
    // Stage 3 onward: effective color.
    color_t eff3_reg, eff4_reg, eff5_reg, eff6_reg, eff7_reg, eff8_reg, eff9_reg, eff10_reg;
    // Stage 4: linear channels. Stage 5: weighted channels. Stage 6: luminance.
    logic [LINW-1:0] lr_reg, lg_reg, lb_reg;
    logic [LUMW-1:0] pr_reg, pg_reg, pb_reg;
    logic [LUMW-1:0] le_reg;
    // Stage 7: contrast fractions. Stage 8: partial products. Stage 9: sums.
    logic [RW-1:0]  nd7_reg, dd7_reg, nl7_reg, dl7_reg;
    logic [RW-1:0]  nd8_reg, dd8_reg, nl8_reg, dl8_reg;
    logic [RW-1:0]  nd9_reg, dd9_reg, nl9_reg, dl9_reg;
    logic [PPW-1:0] p1_pp_reg [4];
    logic [PPW-1:0] p2_pp_reg [4];
    logic [XW-1:0]  p1_reg, p2_reg;
    // Stage 10: choice.
    logic [RW-1:0]  num10_reg, den10_reg;
    logic [31:0]    label10_reg;
    logic           dark10_reg;

    logic [RW-1:0] nd_next, dd_next, nl_next, dl_next;

    always_comb
    begin
        if (lum_dark_reg > le_reg)
        begin
            nd_next = ratio_term(lum_dark_reg);
            dd_next = ratio_term(le_reg);
        end
        else
        begin
            nd_next = ratio_term(le_reg);
            dd_next = ratio_term(lum_dark_reg);
        end
        if (lum_light_reg > le_reg)
        begin
            nl_next = ratio_term(lum_light_reg);
            dl_next = ratio_term(le_reg);
        end
        else
        begin
            nl_next = ratio_term(le_reg);
            dl_next = ratio_term(lum_light_reg);
        end
    end

    function automatic logic [XW-1:0] pp_sum(input logic [PPW-1:0] ll, input logic [PPW-1:0] lh,
                                             input logic [PPW-1:0] hl, input logic [PPW-1:0] hh);
        return (XW'(hh) << (2 * HW)) + ((XW'(lh) + XW'(hl)) << HW) + XW'(ll);
    endfunction

    // Datapath stages; advance together under the pipeline enable.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fill_reg <= s_tdata[31:0];
            back_reg <= s_tdata[63:32];

            sr_reg <= blend_sum(fill_reg.red,   back_reg.red,   fill_reg.alpha);
            sg_reg <= blend_sum(fill_reg.green, back_reg.green, fill_reg.alpha);
            sb_reg <= blend_sum(fill_reg.blue,  back_reg.blue,  fill_reg.alpha);

            eff3_reg <= {ALPHA_OPAQUE, div255(sb_reg), div255(sg_reg), div255(sr_reg)};

            lr_reg   <= lin_rom[eff3_reg.red];
            lg_reg   <= lin_rom[eff3_reg.green];
            lb_reg   <= lin_rom[eff3_reg.blue];
            eff4_reg <= eff3_reg;

            pr_reg   <= LUMW'(WEIGHT_RED)   * LUMW'(lr_reg);
            pg_reg   <= LUMW'(WEIGHT_GREEN) * LUMW'(lg_reg);
            pb_reg   <= LUMW'(WEIGHT_BLUE)  * LUMW'(lb_reg);
            eff5_reg <= eff4_reg;

            le_reg   <= pr_reg + pg_reg + pb_reg;
            eff6_reg <= eff5_reg;

            nd7_reg  <= nd_next;
            dd7_reg  <= dd_next;
            nl7_reg  <= nl_next;
            dl7_reg  <= dl_next;
            eff7_reg <= eff6_reg;

            // nd * dl and nl * dd, split into half-width products.
            p1_pp_reg[0] <= PPW'(nd7_reg[HW-1:0]) * PPW'(dl7_reg[HW-1:0]);
            p1_pp_reg[1] <= PPW'(nd7_reg[HW-1:0]) * PPW'(dl7_reg[RW-1:HW]);
            p1_pp_reg[2] <= PPW'(nd7_reg[RW-1:HW]) * PPW'(dl7_reg[HW-1:0]);
            p1_pp_reg[3] <= PPW'(nd7_reg[RW-1:HW]) * PPW'(dl7_reg[RW-1:HW]);
            p2_pp_reg[0] <= PPW'(nl7_reg[HW-1:0]) * PPW'(dd7_reg[HW-1:0]);
            p2_pp_reg[1] <= PPW'(nl7_reg[HW-1:0]) * PPW'(dd7_reg[RW-1:HW]);
            p2_pp_reg[2] <= PPW'(nl7_reg[RW-1:HW]) * PPW'(dd7_reg[HW-1:0]);
            p2_pp_reg[3] <= PPW'(nl7_reg[RW-1:HW]) * PPW'(dd7_reg[RW-1:HW]);
            nd8_reg  <= nd7_reg;
            dd8_reg  <= dd7_reg;
            nl8_reg  <= nl7_reg;
            dl8_reg  <= dl7_reg;
            eff8_reg <= eff7_reg;

            p1_reg   <= pp_sum(p1_pp_reg[0], p1_pp_reg[1], p1_pp_reg[2], p1_pp_reg[3]);
            p2_reg   <= pp_sum(p2_pp_reg[0], p2_pp_reg[1], p2_pp_reg[2], p2_pp_reg[3]);
            nd9_reg  <= nd8_reg;
            dd9_reg  <= dd8_reg;
            nl9_reg  <= nl8_reg;
            dl9_reg  <= dl8_reg;
            eff9_reg <= eff8_reg;

            // Dark wins when its ratio is at least the light one.
            dark10_reg  <= p1_reg >= p2_reg;
            num10_reg   <= (p1_reg >= p2_reg) ? nd9_reg : nl9_reg;
            den10_reg   <= (p1_reg >= p2_reg) ? dd9_reg : dl9_reg;
            label10_reg <= (p1_reg >= p2_reg) ? dark_reg : light_reg;
            eff10_reg   <= eff9_reg;
        end
    end

    // Contrast quotient.
    logic          div_valid;
    logic [QB-1:0] div_quot;
    logic [PW-1:0] div_payload;

    lcs_divider #(
        .RW (RW),
        .QB (QB),
        .FB (RATIO_FRAC_BITS),
        .PW (PW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (v_reg[10]),
        .num         (num10_reg),
        .den         (den10_reg),
        .in_payload  ({eff10_reg, dark10_reg, label10_reg}),
        .out_valid   (div_valid),
        .quotient    (div_quot),
        .out_payload (div_payload)
    );

    logic [QXW-1:0] quot_ext;
    logic [79:0]    result_data;
    assign quot_ext    = QXW'(div_quot);
    assign result_data = {3'b000, quot_ext[12:0], div_payload[64:33], div_payload[31:0]};

    // Output register with a skid entry behind it.
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        out_user_reg;
    logic [79:0] skid_data_reg;
    logic        skid_user_reg;
    logic        out_load;
    assign out_load = m_tready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= div_valid;
            end
        end
        else if (div_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result_data;
            out_user_reg <= skid_valid_reg ? skid_user_reg : div_payload[32];
        end
        else if (!skid_valid_reg)
        begin
            skid_data_reg <= result_data;
            skid_user_reg <= div_payload[32];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ sv/lcs_checker.sv @@
module lcs_checker
    import lcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    // The blended color is always opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:56] == ALPHA_OPAQUE)
        else $error("effective color alpha is not opaque");

    // The input side backs up only behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind label_contrast_selector lcs_checker u_lcs_checker (.*);

@@ test/tb_label_contrast_selector.sv @@
module tb_label_contrast_selector;
    import lcs_pkg::*;

    localparam int LUMA_FRAC  = 16;
    localparam int RATIO_FRAC = 8;
    localparam int LATENCY    = RATIO_FRAC + 17;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] fill;
        logic [31:0] back;
    } pair_t;

    typedef struct packed {
        logic [31:0] label;
        logic        dark;
        logic [31:0] eff;
        logic [12:0] contrast;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;

    label_contrast_selector dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Linearization table and label registers held by the predictor.
    logic [63:0] srgb_lin [256];
    logic [31:0] dark_reg;
    logic [31:0] light_reg;

    pair_t    pending_pairs[$];
    verdict_t expected_verdicts[$];
    int       mismatches;
    int       cycles;
    bit       hold_sender;
    bit       in_taken;
    int       burst_left;
    int       gap_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fifth power in Q30 with truncation per step.
    function automatic logic [63:0] q30_pow5(input logic [63:0] r);
        logic [63:0] x;
        x = r;
        for (int i = 0; i < 4; i++)
            x = (x * r) >> 30;
        return x;
    endfunction

    task automatic fill_srgb_table();
        logic [63:0] tq, t2, lo, hi, mid, lin;
        for (int v = 0; v < 256; v++)
        begin
            if (v <= 10)
                srgb_lin[v] = ((((64'd25 * v) << LUMA_FRAC) * 2) + 64'd82365) / 64'd164730;
            else
            begin
                tq = (((64'd200 * v + 64'd2805) << 30) + 64'd26902) / 64'd53805;
                t2 = (tq * tq + (64'd1 << 29)) >> 30;
                lo = 0;
                hi = 64'd1 << 30;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    if (q30_pow5(mid) <= t2)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                lin = (t2 * lo) >> 30;
                srgb_lin[v] = (lin + (64'd1 << (29 - LUMA_FRAC))) >> (30 - LUMA_FRAC);
            end
        end
    endtask

    function automatic logic [63:0] luma_of(input logic [31:0] c);
        return 64'd13933 * srgb_lin[c[7:0]] + 64'd46871 * srgb_lin[c[15:8]]
             + 64'd4732 * srgb_lin[c[23:16]];
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] f, input logic [7:0] b,
                                               input logic [7:0] a);
        logic [31:0] s;
        s = f * a + b * (32'd255 - a) + 32'd127;
        return 8'(s / 32'd255);
    endfunction

    // Blend, luminance and exact ratio comparison for one color pair.
    function automatic verdict_t pick_label(input pair_t p);
        verdict_t    v;
        logic [63:0] one, le, ld, ll, nd, dd, nl, dl, num, den;
        logic [127:0] cross_d, cross_l;
        one = 64'd1 << (LUMA_FRAC + 16);
        v.eff = {ALPHA_OPAQUE,
                 mix_channel(p.fill[23:16], p.back[23:16], p.fill[31:24]),
                 mix_channel(p.fill[15:8], p.back[15:8], p.fill[31:24]),
                 mix_channel(p.fill[7:0], p.back[7:0], p.fill[31:24])};
        le = luma_of(v.eff);
        ld = luma_of(dark_reg);
        ll = luma_of(light_reg);
        nd = 20 * (ld > le ? ld : le) + one;
        dd = 20 * (ld > le ? le : ld) + one;
        nl = 20 * (ll > le ? ll : le) + one;
        dl = 20 * (ll > le ? le : ll) + one;
        cross_d = 128'(nd) * 128'(dl);
        cross_l = 128'(nl) * 128'(dd);
        v.dark = cross_d >= cross_l;
        num = v.dark ? nd : nl;
        den = v.dark ? dd : dl;
        v.label = v.dark ? dark_reg : light_reg;
        v.contrast = 13'(((num << RATIO_FRAC) / den));
        return v;
    endfunction

    // Driver: bursts with random gaps, held off when requested. An offered
    // transaction stays unchanged until it is taken.
    always @(negedge clk)
    begin
        if (!s_tvalid || in_taken)
        begin
            if (gap_left > 0)
                gap_left = gap_left - 1;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (!hold_sender && pending_pairs.size() > 0 && gap_left == 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_pairs[0].back, pending_pairs[0].fill};
                burst_left = burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
        // Receiver stalls: long ready phases alternating with stall phases.
        case (cycles % 600 < 200)
            1'b1: m_tready <= 1'b1;
            default: m_tready <= ($urandom_range(0, 2) != 0);
        endcase
    end

    // Monitor: records accepted inputs and compares each result transaction
    // with the oldest prediction.
    always @(posedge clk)
    begin
        verdict_t want;
        cycles <= cycles + 1;
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
            expected_verdicts.push_back(pick_label(pending_pairs.pop_front()));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result with no expectation: tdata=%h", m_tdata);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_tdata[31:0] !== want.label)
                begin
                    $error("label_color exp %h got %h", want.label, m_tdata[31:0]);
                    mismatches = mismatches + 1;
                end
                if (m_tuser !== want.dark)
                begin
                    $error("chose_dark exp %0d got %0d", want.dark, m_tuser);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[63:32] !== want.eff)
                begin
                    $error("effective_color exp %h got %h", want.eff, m_tdata[63:32]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[76:64] !== want.contrast)
                begin
                    $error("contrast_q8 exp %0d got %0d", want.contrast, m_tdata[76:64]);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("label_contrast_selector verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_label(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_DARK_LABEL)
            dark_reg = value;
        else
            light_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_color();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            2: return {8'($urandom_range(0, 1) * 255), 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int n);
        pair_t p;
        for (int i = 0; i < n; i++)
        begin
            p.fill = rand_color();
            p.back = rand_color();
            pending_pairs.push_back(p);
        end
    endtask

    initial
    begin
        logic [31:0] label_sets [4][2];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DARK_LABEL;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_sender = 1'b0;
        in_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        dark_reg = DARK_LABEL_RESET;
        light_reg = LIGHT_LABEL_RESET;
        fill_srgb_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs at reset labels: extremes, opaque, clear, mid grays.
        pending_pairs.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
        pending_pairs.push_back('{32'hFF00_0000, 32'hFFFF_FFFF});
        pending_pairs.push_back('{32'h00FF_FFFF, 32'h0000_0000});
        pending_pairs.push_back('{32'h0000_0000, 32'h00FF_FFFF});
        pending_pairs.push_back('{32'h80FF_FFFF, 32'hFF00_0000});
        pending_pairs.push_back('{32'hFF0A_0A0A, 32'h0});
        pending_pairs.push_back('{32'hFF0B_0B0B, 32'h0});
        pending_pairs.push_back('{32'hFF75_7575, 32'h0});
        pending_pairs.push_back('{32'hFF76_7676, 32'h0});
        pending_pairs.push_back('{32'hFF00_00FF, 32'h0});
        pending_pairs.push_back('{32'hFF00_FF00, 32'h0});
        pending_pairs.push_back('{32'hFFFF_0000, 32'h0});
        pending_pairs.push_back('{32'h01FF_FFFF, 32'hAA55_AA55});
        pending_pairs.push_back('{32'hFE12_3456, 32'h55AB_CDEF});
        wait_drained();

        // Equal labels force ties; equal luminance gives ratio one.
        write_label(REG_DARK_LABEL, 32'h0080_8080);
        write_label(REG_LIGHT_LABEL, 32'hFF80_8080);
        pending_pairs.push_back('{32'hFF80_8080, 32'h0});
        pending_pairs.push_back('{32'h0000_0000, 32'h0080_8080});
        pending_pairs.push_back('{32'hFFFF_FFFF, 32'h0});
        pending_pairs.push_back('{32'hFF00_0000, 32'h0});
        queue_random(10);
        wait_drained();

        // Random phases over several label settings, extremes included.
        label_sets[0] = '{32'h0000_0000, 32'hFFFF_FFFF};
        label_sets[1] = '{32'hFFFF_FFFF, 32'h0000_0000};
        label_sets[2] = '{32'h0, 32'h0};
        label_sets[3] = '{$urandom, $urandom};
        for (int k = 0; k < 4; k++)
        begin
            write_label(REG_DARK_LABEL, label_sets[k][0]);
            write_label(REG_LIGHT_LABEL, label_sets[k][1]);
            queue_random(170);
            // Sender holds off mid-phase until every result is back.
            while (pending_pairs.size() > 85)
                @(posedge clk);
            hold_sender = 1'b1;
            while (s_tvalid || expected_verdicts.size() > 0)
                @(posedge clk);
            hold_sender = 1'b0;
            queue_random(170);
            wait_drained();
        end
        write_label(REG_DARK_LABEL, DARK_LABEL_RESET);
        write_label(REG_LIGHT_LABEL, LIGHT_LABEL_RESET);
        queue_random(60);
        wait_drained();

        if (mismatches == 0)
            $display("label_contrast_selector verification clean");
        else
            $display("label_contrast_selector verification failed");
        $finish;
    end

endmodule
